[sv/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the go-back-N sender window: sequence and
// slot sizes, item classification, queue status and the packed result word.
// ----------------------------------------------------------------------------
package gbn_pkg;

   // Sequence numbers and retransmit buffer
   localparam int SEQ_BITS     = 3;
   localparam int SEQ_COUNT    = 8;
   localparam int SLOTS        = 4;
   localparam int SLOT_BITS    = 2;
   localparam int LIMIT_BITS   = 3;
   localparam int DUP_BITS     = 2;
   localparam int PAYLOAD_BITS = 64;

   // Port payload widths
   localparam int FUNC_BITS     = 2;
   localparam int WORD_BITS     = 64;
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 72;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 3'd4;
   localparam logic [DUP_BITS-1:0]   DUP_TRIGGER = 2'd3;

   // Item kind codes as they arrive on the request channel
   localparam logic [FUNC_BITS-1:0] FUNC_SEND    = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_ACK     = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_TIMEOUT = 2'd2;

   // Timer actions
   localparam logic [1:0] TIMER_NONE  = 2'd0;
   localparam logic [1:0] TIMER_STOP  = 2'd1;
   localparam logic [1:0] TIMER_START = 2'd2;

   // Classified work handed from front to back
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_SEND    = 2'd1,
      KIND_ACK     = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [PAYLOAD_BITS-1:0]   payload;
      logic [SEQ_BITS-1:0]       ack_number;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Result word, laid out exactly as rsp_tdata (lowest field last here)
   typedef struct packed {
      logic [1:0]           timer_cmd;
      logic [WORD_BITS-1:0] tx_payload;
      logic [SEQ_BITS-1:0]  tx_seq;
      logic                 tx_valid;
      logic                 window_full;
      logic                 accepted;
   } result_type;

endpackage

[sv/gbn_front.sv]
// ----------------------------------------------------------------------------
// gbn_front
// Request intake: takes transfers while the queue has room, decodes the
// item kind and drops corrupt acks to a no-op before queuing.
// ----------------------------------------------------------------------------
module gbn_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic [gbn_pkg::FUNC_BITS-1:0]     req_tuser,
   input  gbn_pkg::queue_status_type         queue_status,
   output logic                              push,
   output gbn_pkg::cmd_type                  push_cmd
);
   import gbn_pkg::*;

   logic intact;

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && req_tready;
   assign intact     = req_tdata[WORD_BITS+SEQ_BITS];

   always_comb begin
      push_cmd.payload    = req_tdata[PAYLOAD_BITS-1:0];
      push_cmd.ack_number = req_tdata[WORD_BITS +: SEQ_BITS];
      case (req_tuser)
         FUNC_SEND:    push_cmd.kind = KIND_SEND;
         FUNC_ACK:     push_cmd.kind = intact ? KIND_ACK : KIND_NONE;
         FUNC_TIMEOUT: push_cmd.kind = KIND_TIMEOUT;
         default:      push_cmd.kind = KIND_NONE;
      endcase
   end

endmodule

[sv/gbn_queue.sv]
// ----------------------------------------------------------------------------
// gbn_queue
// Two-entry command queue between intake and execution.
// ----------------------------------------------------------------------------
module gbn_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  gbn_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output gbn_pkg::cmd_type          head_cmd,
   output gbn_pkg::queue_status_type status
);
   import gbn_pkg::*;

   localparam int DEPTH    = 2;
   localparam int PTR_BITS = 1;

   cmd_type                 entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]       count_ff,  count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[sv/gbn_back.sv]
// ----------------------------------------------------------------------------
// gbn_back
// Window engine: holds sequence state, retransmit slots and duplicate counters;
// runs one queued command per cycle into the result register unless stalled.
// ----------------------------------------------------------------------------
module gbn_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [gbn_pkg::LIMIT_BITS-1:0]    csr_wdata,
   input  gbn_pkg::cmd_type                  head_cmd,
   input  gbn_pkg::queue_status_type         queue_status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gbn_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import gbn_pkg::*;

   logic [LIMIT_BITS-1:0]   limit_ff;
   logic [SEQ_BITS-1:0]     next_seq_ff,    next_seq_in;
   logic [SEQ_BITS-1:0]     window_base_ff, window_base_in;
   logic [SEQ_BITS-1:0]     slot_seq_ff     [SLOTS];
   logic [SEQ_BITS-1:0]     slot_seq_in     [SLOTS];
   logic [PAYLOAD_BITS-1:0] slot_payload_ff [SLOTS];
   logic [PAYLOAD_BITS-1:0] slot_payload_in [SLOTS];
   logic [DUP_BITS-1:0]     dup_count_ff    [SEQ_COUNT];
   logic [DUP_BITS-1:0]     dup_count_in    [SEQ_COUNT];
   result_type              result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [LIMIT_BITS-1:0]   eff_limit;
   logic [SEQ_BITS-1:0]     cnt;
   logic [SEQ_BITS-1:0]     ack_delta;
   logic [SEQ_BITS-1:0]     new_cnt;
   logic [SEQ_BITS-1:0]     src;
   logic [DUP_BITS-1:0]     dup_next;
   logic                    hit;

   assign pop        = !queue_status.empty && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff;

   assign eff_limit = (limit_ff > LIMIT_BITS'(SLOTS)) ? LIMIT_BITS'(SLOTS) : limit_ff;
   assign cnt       = next_seq_ff - window_base_ff;
   assign ack_delta = head_cmd.ack_number - window_base_ff;

   always_comb begin
      next_seq_in    = next_seq_ff;
      window_base_in = window_base_ff;
      slot_seq_in    = slot_seq_ff;
      slot_payload_in = slot_payload_ff;
      dup_count_in   = dup_count_ff;
      result_in      = '0;
      dup_next       = '0;
      hit            = 1'b0;
      src            = '0;

      if (pop) begin
         case (head_cmd.kind)
            KIND_SEND: begin
               if (cnt < eff_limit) begin
                  slot_seq_in[cnt[SLOT_BITS-1:0]]     = next_seq_ff;
                  slot_payload_in[cnt[SLOT_BITS-1:0]] = head_cmd.payload;
                  result_in.accepted   = 1'b1;
                  result_in.tx_valid   = 1'b1;
                  result_in.tx_seq     = next_seq_ff;
                  result_in.tx_payload = WORD_BITS'(head_cmd.payload);
                  result_in.timer_cmd  = (cnt == '0) ? TIMER_START : TIMER_NONE;
                  next_seq_in          = next_seq_ff + 1'b1;
               end
            end
            KIND_ACK: begin
               if (ack_delta != '0 && ack_delta <= SEQ_BITS'(SLOTS)) begin
                  // slide: slot i takes slot i+ack_delta, top slots keep contents
                  for (int i = 0; i < SLOTS; i++) begin
                     src = SEQ_BITS'(i) + ack_delta;
                     if (src < SEQ_BITS'(SLOTS)) begin
                        slot_seq_in[i]     = slot_seq_ff[src[SLOT_BITS-1:0]];
                        slot_payload_in[i] = slot_payload_ff[src[SLOT_BITS-1:0]];
                     end
                  end
                  window_base_in      = head_cmd.ack_number;
                  result_in.timer_cmd = (head_cmd.ack_number == next_seq_ff) ?
                                        TIMER_STOP : TIMER_START;
               end else begin
                  dup_next = dup_count_ff[head_cmd.ack_number] + 1'b1;
                  if (dup_next == DUP_TRIGGER) begin
                     // resend lowest slot carrying this number
                     for (int i = 0; i < SLOTS; i++) begin
                        if (!hit && slot_seq_ff[i] == head_cmd.ack_number) begin
                           hit                  = 1'b1;
                           result_in.tx_valid   = 1'b1;
                           result_in.tx_seq     = slot_seq_ff[i];
                           result_in.tx_payload = WORD_BITS'(slot_payload_ff[i]);
                        end
                     end
                     dup_next = '0;
                  end
                  dup_count_in[head_cmd.ack_number] = dup_next;
               end
            end
            KIND_TIMEOUT: begin
               result_in.timer_cmd  = TIMER_START;
               result_in.tx_valid   = 1'b1;
               result_in.tx_seq     = slot_seq_ff[0];
               result_in.tx_payload = WORD_BITS'(slot_payload_ff[0]);
            end
            default: begin
            end
         endcase
      end

      new_cnt               = next_seq_in - window_base_in;
      result_in.window_full = (new_cnt >= eff_limit);

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= LIMIT_RESET;
         next_seq_ff    <= '0;
         window_base_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_seq_ff[i]     <= '0;
            slot_payload_ff[i] <= '0;
         end
         for (int i = 0; i < SEQ_COUNT; i++) begin
            dup_count_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         next_seq_ff     <= next_seq_in;
         window_base_ff  <= window_base_in;
         rsp_valid_ff    <= rsp_valid_in;
         slot_seq_ff     <= slot_seq_in;
         slot_payload_ff <= slot_payload_in;
         dup_count_ff    <= dup_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

endmodule

[sv/go_back_n_sender_window.sv]
// A request transfer into an empty queue is written into a queue entry, then
//   popped and executed into the result register that drives rsp.
// Throughput: one item per cycle while rsp_tready holds high; the window
//   engine executes one queued command per cycle against the window state.
// Reset (synchronous, active high) empties the queue and result register,
//   zeroes sequence state, slots and duplicate counters, window_limit to 4.
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Sender side of a go-back-N link: 3-bit sequence numbers, four-slot
// retransmit buffer, fast retransmit on the third duplicate ack.
// ----------------------------------------------------------------------------
module go_back_n_sender_window (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] payload, [66:64] ack_number, [67] ack_intact, [71:68] zero
   input  logic [gbn_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] func
   input  logic [gbn_pkg::FUNC_BITS-1:0]     req_tuser,
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] accepted, [1] window_full, [2] tx_valid, [5:3] tx_seq,
   // [69:6] tx_payload, [71:70] timer_cmd
   output logic [gbn_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // window_limit register
   input  logic                              csr_we,
   input  logic [gbn_pkg::LIMIT_BITS-1:0]    csr_wdata
);
   import gbn_pkg::*;

   // Front side decodes each transfer into a command; the queue decouples it
   // from the back side, so intake keeps going while a result waits on rsp.
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type queue_status;

   gbn_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   gbn_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   // Back side owns the window: it pops only when the result register is
   // free or being drained, so no result is dropped or repeated.
   gbn_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

`ifndef SYNTHESIS
   // an accepted send is always transmitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2])
      else $error("accepted send without transmit");

   // no transmit means zero sequence and payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[2] |-> rsp_tdata[69:3] == '0)
      else $error("idle transmit fields not cleared");

   // timer code stays in its defined range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:70] != 2'd3)
      else $error("undefined timer command");

   // a request transfer is never lost between intake and execution
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !queue_status.empty)
      else $error("request transfer lost before queue");
`endif

endmodule

[dv/go_back_n_sender_window_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_tb
// Self-checking bench for the go-back-N sender window. A directed table
// covers reset behavior, full and refused windows, slides, the third
// duplicate ack, corrupt acks, unknown kinds and an ack that runs ahead of
// the next sequence. Random traffic follows, with one phase for each
// window_limit value. Every result transfer is compared field by field
// against a typed-in result or the in-bench window model. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_tb;
   import gbn_pkg::*;

   localparam time CLOCK_HALF = 4;
   // Kind code that the block ignores
   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   // Cycles from a request transfer until its result shows up, plus margin
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS = 244;
   localparam int PRINT_CAP = 40;

   typedef struct {
      logic [FUNC_BITS-1:0] func;
      logic [63:0]          payload;
      logic [SEQ_BITS-1:0]  ack_number;
      logic                 ack_intact;
      bit                   has_golden;
      result_type           golden;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [63:0] payload, [66:64] ack_number, [67] ack_intact, [71:68] zero
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   // [1:0] func
   logic [FUNC_BITS-1:0]     req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [0] accepted, [1] window_full, [2] tx_valid, [5:3] tx_seq,
   // [69:6] tx_payload, [71:70] timer_cmd
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [LIMIT_BITS-1:0]    csr_wdata = '0;

   // Window model: state after every request issued so far
   logic [LIMIT_BITS-1:0]    win_limit;
   logic [SEQ_BITS-1:0]      win_next_seq;
   logic [SEQ_BITS-1:0]      win_base;
   logic [SEQ_BITS-1:0]      buf_seq [SLOTS];
   logic [63:0]              buf_payload [SLOTS];
   logic [DUP_BITS-1:0]      dup_hits [SEQ_COUNT];

   result_type               pending_results [$];
   stim_row_type             directed_rows [$];
   int                       mismatch_count = 0;
   int                       result_index = 0;
   bit                       sender_quiet = 1'b0;
   bit                       receiver_quiet = 1'b0;

   go_back_n_sender_window DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Hard stop: far beyond the slowest legal run (about 2000 items, each
   // with a full sender gap, a full receiver stall and the pipeline delay).
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Limit above the slot count behaves as the slot count.
   function automatic logic [LIMIT_BITS-1:0] active_limit();
      return (win_limit > LIMIT_BITS'(SLOTS)) ? LIMIT_BITS'(SLOTS) : win_limit;
   endfunction

   // Advance the window model by one request and return its result.
   function automatic result_type predict_window(logic [FUNC_BITS-1:0] func,
                                                 logic [63:0] payload,
                                                 logic [SEQ_BITS-1:0] ack,
                                                 logic intact);
      result_type           res;
      logic [SEQ_BITS-1:0]  in_flight;
      logic [SEQ_BITS-1:0]  ack_delta;
      logic [DUP_BITS-1:0]  hits;
      bit                   found;
      res = '0;
      in_flight = win_next_seq - win_base;
      case (func)
         FUNC_SEND: begin
            if (in_flight < active_limit()) begin
               buf_seq[in_flight[SLOT_BITS-1:0]] = win_next_seq;
               buf_payload[in_flight[SLOT_BITS-1:0]] = payload;
               res.accepted = 1'b1;
               res.tx_valid = 1'b1;
               res.tx_seq = win_next_seq;
               res.tx_payload = payload;
               // start the timer on the first packet into an empty window
               if (in_flight == 0) res.timer_cmd = TIMER_START;
               win_next_seq = win_next_seq + 1'b1;
            end
         end
         FUNC_ACK: begin
            if (intact) begin
               ack_delta = ack - win_base;
               if (ack_delta >= 1 && ack_delta <= SLOTS) begin
                  // shift down; the top slots keep stale contents
                  for (int i = 0; i + ack_delta < SLOTS; i++) begin
                     buf_seq[i] = buf_seq[i + ack_delta];
                     buf_payload[i] = buf_payload[i + ack_delta];
                  end
                  win_base = ack;
                  res.timer_cmd = (win_base == win_next_seq) ? TIMER_STOP : TIMER_START;
               end else begin
                  hits = dup_hits[ack] + 1'b1;
                  if (hits == DUP_TRIGGER) begin
                     found = 1'b0;
                     for (int i = 0; i < SLOTS; i++) begin
                        if (!found && buf_seq[i] == ack) begin
                           found = 1'b1;
                           res.tx_valid = 1'b1;
                           res.tx_seq = buf_seq[i];
                           res.tx_payload = buf_payload[i];
                        end
                     end
                     hits = '0;
                  end
                  dup_hits[ack] = hits;
               end
            end
         end
         FUNC_TIMEOUT: begin
            res.timer_cmd = TIMER_START;
            res.tx_valid = 1'b1;
            res.tx_seq = buf_seq[0];
            res.tx_payload = buf_payload[0];
         end
         default: ;
      endcase
      res.window_full = ((win_next_seq - win_base) >= active_limit());
      return res;
   endfunction

   // Toggle quiet stretches now and then; in a quiet stretch never wait.
   function automatic int pick_wait(inout bit quiet);
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("%0t result %0d: %s expected %h got %h",
                  $time, result_index, what, want, got);
   endtask

   task automatic check_result(result_type got);
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result, rsp_tdata", '0, got[63:0]);
         return;
      end
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted)
         report_mismatch("accepted", 64'(want.accepted), 64'(got.accepted));
      if (got.window_full !== want.window_full)
         report_mismatch("window_full", 64'(want.window_full), 64'(got.window_full));
      if (got.tx_valid !== want.tx_valid)
         report_mismatch("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
      if (got.tx_seq !== want.tx_seq)
         report_mismatch("tx_seq", 64'(want.tx_seq), 64'(got.tx_seq));
      if (got.tx_payload !== want.tx_payload)
         report_mismatch("tx_payload", want.tx_payload, got.tx_payload);
      if (got.timer_cmd !== want.timer_cmd)
         report_mismatch("timer_cmd", 64'(want.timer_cmd), 64'(got.timer_cmd));
   endtask

   // Issue one request. Enter and leave at a falling edge; tvalid stays
   // high on exit so back-to-back requests need no extra assignment.
   task automatic drive_request(logic [FUNC_BITS-1:0] func, logic [63:0] payload,
                                logic [SEQ_BITS-1:0] ack, logic intact,
                                bit has_golden, result_type golden);
      int         gap;
      result_type predicted;
      gap = pick_wait(sender_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, intact, ack, payload};
      req_tuser <= func;
      // model runs in issue order; typed-in rows still advance its state
      predicted = predict_window(func, payload, ack, intact);
      pending_results.push_back(has_golden ? golden : predicted);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every result is back, then let the pipe settle.
   task automatic wait_for_drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_window_limit(logic [LIMIT_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      win_limit = value;
   endtask

   task automatic add_row(logic [FUNC_BITS-1:0] func, logic [63:0] payload,
                          logic [SEQ_BITS-1:0] ack, logic intact,
                          bit has_golden = 1'b0, result_type golden = '0);
      stim_row_type row;
      row.func = func;
      row.payload = payload;
      row.ack_number = ack;
      row.ack_intact = intact;
      row.has_golden = has_golden;
      row.golden = golden;
      directed_rows.push_back(row);
   endtask

   // Build one random request from the current window state. Most traffic
   // is well formed (sends, in-window acks, repeated acks at the base) so
   // the window fills, slides and fast-retransmits; the rest is noise.
   task automatic random_request();
      logic [SEQ_BITS-1:0]  in_flight;
      logic [63:0]          payload;
      logic [FUNC_BITS-1:0] func;
      logic [SEQ_BITS-1:0]  ack;
      logic                 intact;
      int                   pick;
      in_flight = win_next_seq - win_base;
      payload = {$urandom, $urandom};
      ack = SEQ_BITS'($urandom_range(0, SEQ_COUNT - 1));
      intact = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         func = FUNC_SEND;
      end else if (pick < 65) begin
         func = FUNC_ACK;
         if (in_flight >= 1 && in_flight <= SLOTS)
            ack = win_base + SEQ_BITS'($urandom_range(1, in_flight));
         else
            ack = win_base + SEQ_BITS'($urandom_range(1, SLOTS));
      end else if (pick < 80) begin
         func = FUNC_ACK;
         ack = ($urandom_range(0, 3) == 0) ? win_base - 1'b1 : win_base;
      end else if (pick < 86) begin
         func = FUNC_ACK;
         intact = 1'($urandom_range(0, 1));
      end else if (pick < 90) begin
         func = FUNC_ACK;
         intact = 1'b0;
      end else if (pick < 97) begin
         func = FUNC_TIMEOUT;
         intact = 1'($urandom_range(0, 1));
      end else begin
         func = FUNC_UNUSED;
         intact = 1'($urandom_range(0, 1));
      end
      drive_request(func, payload, ack, intact, 1'b0, '0);
   endtask

   // Result side: stall at random, then take one transfer and check it.
   initial begin
      while (reset) @(negedge clock);
      forever begin
         int stall;
         stall = pick_wait(receiver_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_result(result_type'(rsp_tdata));
         result_index++;
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed table, random phases, final drain.
   initial begin
      logic [LIMIT_BITS-1:0] phase_limits [8];
      result_type            gold;
      phase_limits = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};

      // Mirror the reset state of the block.
      win_limit = LIMIT_RESET;
      win_next_seq = '0;
      win_base = '0;
      for (int i = 0; i < SLOTS; i++) begin
         buf_seq[i] = '0;
         buf_payload[i] = '0;
      end
      for (int i = 0; i < SEQ_COUNT; i++) dup_hits[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Timeout right after reset resends an empty slot 0 and starts the timer.
      gold = '0;
      gold.tx_valid = 1'b1;
      gold.timer_cmd = TIMER_START;
      add_row(FUNC_TIMEOUT, 64'h0, 3'd0, 1'b0, 1'b1, gold);
      // Corrupt ack and unknown kind: nothing happens.
      add_row(FUNC_ACK, 64'h0, 3'd7, 1'b0, 1'b1, '0);
      add_row(FUNC_UNUSED, '1, 3'd7, 1'b1, 1'b1, '0);
      // First send into an empty window.
      gold = '0;
      gold.accepted = 1'b1;
      gold.tx_valid = 1'b1;
      gold.tx_payload = '1;
      gold.timer_cmd = TIMER_START;
      add_row(FUNC_SEND, '1, 3'd0, 1'b0, 1'b1, gold);
      add_row(FUNC_SEND, 64'h0, 3'd0, 1'b0);
      add_row(FUNC_SEND, 64'h5555_5555_5555_5555, 3'd0, 1'b0);
      add_row(FUNC_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 3'd0, 1'b0);
      // Window full: refused send.
      gold = '0;
      gold.window_full = 1'b1;
      add_row(FUNC_SEND, 64'h1234_5678_9ABC_DEF0, 3'd0, 1'b0, 1'b1, gold);
      // Three duplicates at the base: the third resends sequence 0.
      add_row(FUNC_ACK, 64'h0, 3'd0, 1'b1);
      add_row(FUNC_ACK, 64'h0, 3'd0, 1'b1);
      add_row(FUNC_ACK, 64'h0, 3'd0, 1'b1);
      add_row(FUNC_TIMEOUT, 64'h0, 3'd0, 1'b1);
      // Slide by two, a duplicate outside the window, slide to empty.
      add_row(FUNC_ACK, 64'h0, 3'd2, 1'b1);
      add_row(FUNC_ACK, 64'h0, 3'd7, 1'b1);
      add_row(FUNC_ACK, 64'h0, 3'd4, 1'b1);
      // Timeout on an empty window still resends slot 0.
      add_row(FUNC_TIMEOUT, 64'h0, 3'd0, 1'b0);
      // Ack four ahead of an empty window: the count wraps high.
      add_row(FUNC_ACK, 64'h0, 3'd0, 1'b1);
      add_row(FUNC_SEND, 64'hFFFF_0000_FFFF_0000, 3'd0, 1'b0);
      add_row(FUNC_ACK, 64'h0, 3'd4, 1'b1);
      // Third duplicate with no slot holding that number.
      add_row(FUNC_ACK, 64'h0, 3'd1, 1'b1);
      add_row(FUNC_ACK, 64'h0, 3'd1, 1'b1);
      add_row(FUNC_ACK, 64'h0, 3'd1, 1'b1);
      add_row(FUNC_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0);
      add_row(FUNC_ACK, 64'h0, 3'd5, 1'b0, 1'b1, '0);

      foreach (directed_rows[i])
         drive_request(directed_rows[i].func, directed_rows[i].payload,
                       directed_rows[i].ack_number, directed_rows[i].ack_intact,
                       directed_rows[i].has_golden, directed_rows[i].golden);
      req_tvalid <= 1'b0;
      wait_for_drain();

      // One phase per limit; the register changes only with the block idle.
      foreach (phase_limits[p]) begin
         write_window_limit(phase_limits[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // phase 0 only: stop sending mid-phase until every result is back
            if (n == PHASE_ITEMS / 2 && p == 0) begin
               req_tvalid <= 1'b0;
               wait_for_drain();
            end
            random_request();
         end
         req_tvalid <= 1'b0;
         wait_for_drain();
      end

      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
